/* rtl/core/egcd_pkg.sv */
// Shared types and constants for the signed extended GCD unit.
`timescale 1ns / 1ps

package egcd_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef struct packed {
      logic signed [WORD_W-1:0] a_value;
      logic signed [WORD_W-1:0] b_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] gcd_value;
      logic signed [WORD_W-1:0] coef_a;
      logic signed [WORD_W-1:0] coef_b;
   } rsp_type;

   // A classified job as it travels from the front to the back.
   typedef struct packed {
      req_type operands;
      logic    b_zero;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/egcd_front.sv */
// Front stage: accepts operand beats and marks the zero-divisor case.
`timescale 1ns / 1ps

module egcd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  egcd_pkg::req_type            req_data,
   input  egcd_pkg::queue_status_type   queue_status,
   output logic                         job_valid,
   output egcd_pkg::job_type            job_data
);

   logic              front_valid_ff;
   logic              front_valid_in;
   egcd_pkg::job_type job_ff;
   egcd_pkg::job_type job_in;
   logic              accept;
   logic              move;

   assign full   = front_valid_ff && queue_status.full;
   assign accept = push && !full;
   assign move   = front_valid_ff && !queue_status.full;

   always_comb begin
      front_valid_in = accept || (front_valid_ff && !move);
      job_in         = job_ff;
      if (accept) begin
         job_in.operands = req_data;
         job_in.b_zero   = (req_data.b_value == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = move;
   assign job_data  = job_ff;

endmodule

/* rtl/core/egcd_queue.sv */
// Short register queue that decouples the front stage from the back engine.
`timescale 1ns / 1ps

module egcd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  egcd_pkg::job_type            wr_data,
   input  logic                         rd_en,
   output egcd_pkg::job_type            rd_data,
   output egcd_pkg::queue_status_type   status
);

   egcd_pkg::job_type                          entry_ff [egcd_pkg::QUEUE_DEPTH];
   logic [egcd_pkg::QUEUE_PTR_W-1:0]           wr_ptr_ff;
   logic [egcd_pkg::QUEUE_PTR_W-1:0]           wr_ptr_in;
   logic [egcd_pkg::QUEUE_PTR_W-1:0]           rd_ptr_ff;
   logic [egcd_pkg::QUEUE_PTR_W-1:0]           rd_ptr_in;
   logic [egcd_pkg::QUEUE_CNT_W-1:0]           count_ff;
   logic [egcd_pkg::QUEUE_CNT_W-1:0]           count_in;
   logic                                       do_wr;
   logic                                       do_rd;

   assign status.full  = (count_ff == egcd_pkg::QUEUE_CNT_W'(egcd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_data      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= egcd_pkg::QUEUE_CNT_W'(egcd_pkg::QUEUE_DEPTH))
      else $error("queue occupancy above its depth");

endmodule

/* rtl/core/egcd_back.sv */
// Back engine: Euclid steps over a radix-2 divider and one shared multiplier.
`timescale 1ns / 1ps

module egcd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_ready,
   input  egcd_pkg::job_type            job_data,
   output logic                         job_pop,
   output logic                         empty,
   input  logic                         pop,
   output egcd_pkg::rsp_type            rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MULS  = 3'd3;
   localparam logic [2:0] S_MULT  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int unsigned W     = egcd_pkg::WORD_W;
   localparam int unsigned CNT_W = $clog2(W);

   logic [2:0]       state_ff, state_in;
   logic [W-1:0]     rp_ff, rp_in;
   logic [W-1:0]     rc_ff, rc_in;
   logic [W-1:0]     sp_ff, sp_in;
   logic [W-1:0]     sc_ff, sc_in;
   logic [W-1:0]     tp_ff, tp_in;
   logic [W-1:0]     tc_ff, tc_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dmag_ff, dmag_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     prod_ff, prod_in;
   logic             out_valid_ff, out_valid_in;
   egcd_pkg::rsp_type out_ff, out_in;

   logic [W:0]       trial;
   logic             trial_ge;
   logic [W-1:0]     q_word;
   logic [W-1:0]     mul_b;
   logic [W-1:0]     mul_low;
   logic [W-1:0]     r_next;
   logic             out_free;

   // One restoring division step: shift in the next dividend bit and subtract if it fits.
   assign trial    = {rem_ff, quo_ff[W-1]};
   assign trial_ge = (trial >= {1'b0, dmag_ff});

   // Truncating division: quotient negative when signs differ, remainder takes the
   // sign of the dividend. Coefficients only need their low word, so so does q.
   assign q_word   = (rp_ff[W-1] ^ rc_ff[W-1]) ? W'(-quo_ff) : quo_ff;
   assign r_next   = rp_ff[W-1] ? W'(-rem_ff) : rem_ff;
   assign mul_b    = (state_ff == S_MULS) ? sc_ff : tc_ff;
   assign mul_low  = q_word * mul_b;

   assign out_free = !out_valid_ff || pop;
   assign job_pop  = (state_ff == S_IDLE) && job_ready;

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      rc_in        = rc_ff;
      sp_in        = sp_ff;
      sc_in        = sc_ff;
      tp_in        = tp_ff;
      tc_in        = tc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      unique case (state_ff)
         S_IDLE: begin
            if (job_ready) begin
               rp_in    = job_data.operands.a_value;
               rc_in    = job_data.operands.b_value;
               sp_in    = W'(1);
               sc_in    = '0;
               tp_in    = '0;
               tc_in    = W'(1);
               state_in = job_data.b_zero ? S_DONE : S_SETUP;
            end
         end
         S_SETUP: begin
            quo_in   = rp_ff[W-1] ? W'(-rp_ff) : rp_ff;
            dmag_in  = rc_ff[W-1] ? W'(-rc_ff) : rc_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = trial_ge ? W'(trial - {1'b0, dmag_ff}) : trial[W-1:0];
            quo_in = {quo_ff[W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(W - 1)) begin
               state_in = S_MULS;
            end
         end
         S_MULS: begin
            prod_in  = mul_low;
            state_in = S_MULT;
         end
         S_MULT: begin
            sp_in    = sc_ff;
            sc_in    = sp_ff - prod_ff;
            prod_in  = mul_low;
            state_in = S_FIN;
         end
         S_FIN: begin
            tp_in    = tc_ff;
            tc_in    = tp_ff - prod_ff;
            rp_in    = rc_ff;
            rc_in    = r_next;
            state_in = (r_next == '0) ? S_DONE : S_SETUP;
         end
         S_DONE: begin
            if (out_free) begin
               out_in.gcd_value = rp_ff;
               out_in.coef_a    = sp_ff;
               out_in.coef_b    = tp_ff;
               out_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff   <= rp_in;
      rc_ff   <= rc_in;
      sp_ff   <= sp_in;
      sc_ff   <= sc_in;
      tp_ff   <= tp_in;
      tc_ff   <= tc_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dmag_ff != '0)
      else $error("division started with a zero divisor");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MULS |-> rem_ff < dmag_ff)
      else $error("division remainder not below divisor");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> out_valid_ff && $stable(out_ff))
      else $error("waiting result changed or vanished");

endmodule

/* rtl/core/extended_gcd_signed32_unit.sv */
// Top level of the signed 32-bit extended GCD unit.
`timescale 1ns / 1ps

// Usage: the operand channel is a queue write side. Drive req_data and raise push;
// a beat is taken at a rising edge with push high and full low. The result channel is
// a queue read side: while empty is low, rsp_data holds the oldest result (gcd, then
// the coefficients of a and b), and a rising edge with pop high takes it.
// A front stage registers each operand beat and flags a zero b; a two-entry queue
// then feeds the back engine, so new beats are taken while the engine works and while
// a finished result waits in the output register.
// Engine: each Euclid step runs a setup state, a full pass of the radix-2 restoring
// divider, then states that use the shared 32x32 multiplier for the two coefficient
// updates. With b zero an item skips the Euclid steps and goes straight to its
// result; the divider sets the sustained rate.
// Reset clears the stage, queue and engine control and drops any waiting result.
// If the receiver does not pop, the finished result stays put, the engine holds its
// next result, and full rises once the front stage and the queue have filled up.
module extended_gcd_signed32_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  egcd_pkg::req_type   req_data,
   output logic                empty,
   input  logic                pop,
   output egcd_pkg::rsp_type   rsp_data
);

   logic                       front_job_valid;
   egcd_pkg::job_type          front_job;
   egcd_pkg::queue_status_type queue_status;
   egcd_pkg::job_type          queue_job;
   logic                       back_pop;

   egcd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .queue_status (queue_status),
      .job_valid    (front_job_valid),
      .job_data     (front_job)
   );

   egcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_job_valid),
      .wr_data (front_job),
      .rd_en   (back_pop),
      .rd_data (queue_job),
      .status  (queue_status)
   );

   // The engine pulls one job whenever it is idle and the queue has one.
   egcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (!queue_status.empty),
      .job_data  (queue_job),
      .job_pop   (back_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/tb_extended_gcd_signed32_unit.sv */
// Self-checking testbench for the signed 32-bit extended GCD unit.
`timescale 1ns / 1ps

module tb_extended_gcd_signed32_unit;

   // Bounds of a 32-bit two's complement word, used all over the corner cases.
   localparam logic signed [egcd_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [egcd_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   // Fibonacci numbers this high drive the Euclid loop through its longest chain.
   localparam int FIB_TOP = 46;

   // Each random phase gets roughly a quarter of the random beats.
   localparam int RANDOM_BEATS_PER_PHASE = 88;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   egcd_pkg::req_type req_data;
   logic              empty;
   logic              pop;
   egcd_pkg::rsp_type rsp_data;

   // Results that the unit still owes, oldest first.
   egcd_pkg::rsp_type bezout_expected_q[$];

   int mismatch_count;
   int beats_sent;
   int results_checked;

   // Chance, in percent, that the operand side idles or the result side stalls
   // in a given cycle. The test tasks change these from phase to phase.
   int operand_idle_pct;
   int result_stall_pct;

   extended_gcd_signed32_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // 10 ns clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The expected result of one operand pair. The remainder chain runs on 64-bit
   // signed values so that the most negative word divided by minus one does not
   // overflow; SystemVerilog division truncates toward zero just as the unit does.
   // The coefficients wrap at 64 bits and only their low word is kept.
   function automatic egcd_pkg::rsp_type predict_bezout(egcd_pkg::req_type operands);
      longint            rem_prev;
      longint            rem_cur;
      longint            rem_next;
      longint            quot;
      longint            ca_prev;
      longint            ca_cur;
      longint            ca_next;
      longint            cb_prev;
      longint            cb_cur;
      longint            cb_next;
      egcd_pkg::rsp_type result;
      rem_prev = longint'(operands.a_value);
      rem_cur  = longint'(operands.b_value);
      ca_prev  = 1;
      ca_cur   = 0;
      cb_prev  = 0;
      cb_cur   = 1;
      while (rem_cur != 0) begin
         quot     = rem_prev / rem_cur;
         rem_next = rem_prev - quot * rem_cur;
         ca_next  = ca_prev - quot * ca_cur;
         cb_next  = cb_prev - quot * cb_cur;
         rem_prev = rem_cur;
         rem_cur  = rem_next;
         ca_prev  = ca_cur;
         ca_cur   = ca_next;
         cb_prev  = cb_cur;
         cb_cur   = cb_next;
      end
      result.gcd_value = rem_prev[egcd_pkg::WORD_W-1:0];
      result.coef_a    = ca_prev[egcd_pkg::WORD_W-1:0];
      result.coef_b    = cb_prev[egcd_pkg::WORD_W-1:0];
      return result;
   endfunction

   function automatic longint fibonacci(int n);
      longint lo;
      longint hi;
      longint nxt;
      lo = 0;
      hi = 1;
      repeat (n) begin
         nxt = lo + hi;
         lo  = hi;
         hi  = nxt;
      end
      return lo;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // Sends one operand beat. The inputs change at the falling edge; the beat counts as
   // taken at the first rising edge with full low, and its expectation is queued then.
   // Push is left high afterwards, so back-to-back beats never drop it in between.
   task automatic send_operands(input logic signed [egcd_pkg::WORD_W-1:0] a,
                                input logic signed [egcd_pkg::WORD_W-1:0] b);
      egcd_pkg::req_type beat;
      beat.a_value = a;
      beat.b_value = b;
      @(negedge clock);
      while ($urandom_range(99) < operand_idle_pct) begin
         push     <= 1'b0;
         req_data <= {$urandom, $urandom};
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      do
         @(posedge clock);
      while (full);
      bezout_expected_q.push_back(predict_bezout(beat));
      beats_sent++;
   endtask

   // Drops push, then waits until every owed result has come back.
   task automatic drain_results;
      @(negedge clock);
      push <= 1'b0;
      while (bezout_expected_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The result side stalls at random at each falling edge and stays quiet in reset.
   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= result_stall_pct);
   end

   // Every result beat is checked against the oldest expectation, field by field.
   always @(posedge clock) begin
      egcd_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (bezout_expected_q.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: gcd %0d u %0d v %0d",
                                      rsp_data.gcd_value, rsp_data.coef_a, rsp_data.coef_b));
         end else begin
            want = bezout_expected_q.pop_front();
            results_checked++;
            if (rsp_data.gcd_value !== want.gcd_value)
               report_mismatch($sformatf("gcd_value: expected %0d, got %0d",
                                         want.gcd_value, rsp_data.gcd_value));
            if (rsp_data.coef_a !== want.coef_a)
               report_mismatch($sformatf("coef_a: expected %0d, got %0d",
                                         want.coef_a, rsp_data.coef_a));
            if (rsp_data.coef_b !== want.coef_b)
               report_mismatch($sformatf("coef_b: expected %0d, got %0d",
                                         want.coef_b, rsp_data.coef_b));
         end
      end
   end

   // Zero operands: a zero b skips the loop entirely, a zero a takes a single step.
   task automatic test_zero_operands;
      send_operands(32'sd0, 32'sd0);
      send_operands(32'sd5, 32'sd0);
      send_operands(-32'sd1, 32'sd0);
      send_operands(WORD_MIN, 32'sd0);
      send_operands(WORD_MAX, 32'sd0);
      send_operands(32'sd0, 32'sd7);
      send_operands(32'sd0, WORD_MIN);
      drain_results();
   endtask

   // Word extremes and sign mixes. The most negative word over minus one gives a
   // first quotient of plus two to the 31st, which must not be treated as overflow.
   task automatic test_word_extremes;
      send_operands(WORD_MIN, -32'sd1);
      send_operands(WORD_MIN, 32'sd1);
      send_operands(WORD_MIN, WORD_MIN);
      send_operands(WORD_MAX, WORD_MAX);
      send_operands(WORD_MAX, WORD_MIN);
      send_operands(WORD_MIN, WORD_MAX);
      send_operands(-32'sd1, -32'sd1);
      send_operands(32'sd1, -32'sd1);
      send_operands(-32'sd12, 32'sd18);
      send_operands(32'sd240, -32'sd46);
      send_operands(-32'sd240, -32'sd46);
      drain_results();
   endtask

   // Consecutive Fibonacci numbers make the longest remainder chains the
   // 32-bit range allows, and the largest coefficients.
   task automatic test_longest_chains;
      logic signed [egcd_pkg::WORD_W-1:0] fib_hi;
      logic signed [egcd_pkg::WORD_W-1:0] fib_lo;
      fib_hi = egcd_pkg::WORD_W'(fibonacci(FIB_TOP));
      fib_lo = egcd_pkg::WORD_W'(fibonacci(FIB_TOP - 1));
      send_operands(fib_hi, fib_lo);
      send_operands(fib_lo, fib_hi);
      send_operands(-fib_hi, fib_lo);
      send_operands(fib_hi, -fib_lo);
      drain_results();
   endtask

   // One random operand pair. Half are well-formed pairs meant to exercise the
   // loop at various depths; the rest are raw words, zero operands and corner values.
   task automatic pick_operands(output logic signed [egcd_pkg::WORD_W-1:0] a,
                                output logic signed [egcd_pkg::WORD_W-1:0] b);
      int                                 pick;
      int                                 n;
      int unsigned                        factor;
      logic signed [egcd_pkg::WORD_W-1:0] tmp;
      pick = $urandom_range(99);
      if (pick < 35) begin
         a = $urandom;
         b = $urandom;
      end else if (pick < 55) begin
         a = $urandom_range(2000) - 1000;
         b = $urandom_range(2000) - 1000;
      end else if (pick < 70) begin
         // Consecutive Fibonacci numbers, in either order and with random signs.
         n = $urandom_range(FIB_TOP, 2);
         a = egcd_pkg::WORD_W'(fibonacci(n));
         b = egcd_pkg::WORD_W'(fibonacci(n - 1));
         if ($urandom_range(1)) a = -a;
         if ($urandom_range(1)) b = -b;
         if ($urandom_range(1)) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
      end else if (pick < 85) begin
         // A shared factor, so the gcd is not just plus or minus one.
         factor = $urandom_range(65535, 1);
         a = factor * $urandom_range(32767, 1);
         b = factor * $urandom_range(32767, 1);
         if ($urandom_range(1)) a = -a;
         if ($urandom_range(1)) b = -b;
      end else if (pick < 93) begin
         // One operand zero.
         a = $urandom;
         b = 32'sd0;
         if ($urandom_range(1)) begin
            b = a;
            a = 32'sd0;
         end
      end else begin
         // Extremes against anything.
         case ($urandom_range(3))
            0:       a = WORD_MIN;
            1:       a = WORD_MAX;
            2:       a = -32'sd1;
            default: a = 32'sd1;
         endcase
         b = $urandom;
         if ($urandom_range(1)) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
      end
   endtask

   task automatic run_random_beats(input int count);
      logic signed [egcd_pkg::WORD_W-1:0] a;
      logic signed [egcd_pkg::WORD_W-1:0] b;
      repeat (count) begin
         pick_operands(a, b);
         send_operands(a, b);
      end
      drain_results();
   endtask

   task automatic test_random_no_idle;
      operand_idle_pct = 0;
      result_stall_pct = 0;
      run_random_beats(RANDOM_BEATS_PER_PHASE);
   endtask

   task automatic test_random_operand_idle;
      operand_idle_pct = 58;
      result_stall_pct = 0;
      run_random_beats(RANDOM_BEATS_PER_PHASE);
   endtask

   task automatic test_random_result_stall;
      operand_idle_pct = 0;
      result_stall_pct = 58;
      run_random_beats(RANDOM_BEATS_PER_PHASE);
   endtask

   task automatic test_random_both_idle;
      operand_idle_pct = 25;
      result_stall_pct = 25;
      run_random_beats(RANDOM_BEATS_PER_PHASE);
   endtask

   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      req_data         = '0;
      mismatch_count   = 0;
      beats_sent       = 0;
      results_checked  = 0;
      operand_idle_pct = 0;
      result_stall_pct = 0;

      // Reset is held from time zero and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_operands();
      test_word_extremes();
      test_longest_chains();
      test_random_no_idle();
      test_random_operand_idle();
      test_random_result_stall();
      test_random_both_idle();

      // Let any stray result surface before the verdict.
      repeat (50) @(posedge clock);

      $display("Covered %0d operand beats and %0d result beats: zero operands, word extremes,",
               beats_sent, results_checked);
      $display("longest Fibonacci chains and random pairs under four idle and stall mixes.");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #40_000_000;
      $display("Timeout with %0d results still owed", bezout_expected_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/egcd_pkg.sv
rtl/core/egcd_front.sv
rtl/core/egcd_queue.sv
rtl/core/egcd_back.sv
rtl/core/extended_gcd_signed32_unit.sv
tb/sv/tb_extended_gcd_signed32_unit.sv
